// ===== rtl/seven_segment_scan_blink_driver_macros.svh =====
// assertion macros for the seven-segment scan driver checker
`ifndef SEVEN_SEGMENT_SCAN_BLINK_DRIVER_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_BLINK_DRIVER_MACROS_SVH

// implication checked outside reset
`define SSD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: label failed");

// next-cycle implication that also holds through reset
`define SSD_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: label failed");

`endif

// ===== rtl/ssd_pkg.sv =====
// shared types, codes and segment font for the seven-segment scan driver
package ssd_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int IDX_W = $clog2(DIGIT_COUNT);
  localparam int SEG_W = 8;
  localparam int ROW_W = DIGIT_COUNT * SEG_W;
  localparam int CFG_W = 16;

  localparam logic [2:0] OP_SCAN       = 3'd0;
  localparam logic [2:0] OP_MS_TICK    = 3'd1;
  localparam logic [2:0] OP_NUM_BLANK  = 3'd2;
  localparam logic [2:0] OP_NUM_ZERO   = 3'd3;
  localparam logic [2:0] OP_ERROR      = 3'd4;
  localparam logic [2:0] OP_PASS_FAIL  = 3'd5;
  localparam logic [2:0] OP_TWO_DIGIT  = 3'd6;

  localparam logic [1:0] REG_DRIVE_MODE   = 2'd0;
  localparam logic [1:0] REG_BLINK_MASK   = 2'd1;
  localparam logic [1:0] REG_BLINK_PERIOD = 2'd2;
  localparam logic [1:0] REG_COMMON_ANODE = 2'd3;

  localparam logic [1:0] MODE_DARK   = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_BLINK  = 2'd2;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_E     = 8'h79;
  localparam logic [7:0] SEG_R     = 8'h77;
  localparam logic [31:0] PASS_ROW = {8'h6D, 8'h6D, 8'h77, 8'h73};
  localparam logic [31:0] FAIL_ROW = {8'h38, 8'h30, 8'h77, 8'h71};

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] digit_enable;
    logic [7:0] segment_lines;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] row;
  } fill_t;

  function automatic logic [7:0] font(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'h3F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5B;
      4'd3: s = 8'h4F;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/ssd_fill.sv =====
// pattern encoder: turns a write item into a full row of digit segments
module ssd_fill (
  input  logic            fire,
  input  ssd_pkg::in_item_t item,
  output ssd_pkg::fill_t  fill
);
  import ssd_pkg::*;

  logic [15:0] v;
  logic [13:0] lo;
  logic        in_range;
  logic [28:0] prod1000;
  logic [27:0] prod100;
  logic [29:0] prod10;
  logic [3:0]  q1000;
  logic [6:0]  q100;
  logic [9:0]  q10;
  logic [3:0]  d0, d1, d2, d3;
  logic [7:0]  lead;
  logic [7:0]  g0, g1, g2;

  always_comb begin
    v        = item.value;
    lo       = v[13:0];
    in_range = v <= 16'd9999;
    prod1000 = 29'(lo) * 29'd16778;
    prod100  = 28'(lo) * 28'd10486;
    prod10   = 30'(lo) * 30'd52429;
    q1000    = prod1000[27:24];
    q100     = prod100[26:20];
    q10      = prod10[28:19];
    d0       = q1000;
    d1       = 4'(q100 - 7'(q1000) * 7'd10);
    d2       = 4'(q10 - 10'(q100) * 10'd10);
    d3       = 4'(lo - 14'(q10) * 14'd10);
    lead     = (item.op == OP_NUM_ZERO) ? font(4'd0) : SEG_BLANK;
    g0       = (lo < 14'd1000) ? lead : font(d0);
    g1       = (lo < 14'd100) ? lead : font(d1);
    g2       = (lo < 14'd10) ? lead : font(d2);
    fill.we  = 1'b0;
    fill.row = '0;
    case (item.op)
      OP_NUM_BLANK, OP_NUM_ZERO: begin
        fill.we = fire;
        if (in_range) fill.row = {font(d3), g2, g1, g0};
      end
      OP_ERROR: begin
        fill.we  = fire && (v <= 16'd3);
        fill.row = {font(v[3:0]), SEG_R, SEG_R, SEG_E};
      end
      OP_PASS_FAIL: begin
        fill.we  = fire && (v <= 16'd1);
        fill.row = v[0] ? FAIL_ROW : PASS_ROW;
      end
      OP_TWO_DIGIT: begin
        fill.we = fire;
        if (v <= 16'd99) fill.row = {font(d3), font(d2), SEG_BLANK, SEG_BLANK};
      end
      default: fill.we = 1'b0;
    endcase
  end

endmodule

// ===== rtl/ssd_store.sv =====
// segment store: two-bank synchronous memory, new rows land in the idle bank
module ssd_store (
  input  logic                    clk,
  input  logic                    rst,
  input  ssd_pkg::fill_t          fill,
  input  logic                    rd_en,
  output logic [ssd_pkg::ROW_W-1:0] rd_data
);
  import ssd_pkg::*;

  logic [ROW_W-1:0] mem [2];
  logic [ROW_W-1:0] rd_raw;
  logic [1:0]       bank_valid;
  logic             active;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (fill.we) mem[~active] <= fill.row;
    if (rd_en) rd_raw <= mem[active];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_valid <= '0;
      active     <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      if (fill.we) begin
        bank_valid[~active] <= 1'b1;
        active              <= ~active;
      end
      if (rd_en) rd_valid <= bank_valid[active];
    end
  end

  // a bank never written reads as all blank
  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

// ===== rtl/seven_segment_scan_blink_driver.sv =====
// Four-digit multiplexed seven-segment driver with blinking. One item is
// accepted per clock while input ready is high: scan ticks, millisecond
// ticks and pattern writes. A scan tick reads the two-bank segment memory
// into the memory read stage at its transfer edge, and the output register
// loads from that stage once it can advance. Input ready drops only while
// both the memory read stage and the output register hold results the
// consumer has not taken. Pattern writes update the whole display row and
// are visible to the next scan.
module seven_segment_scan_blink_driver (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ssd_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ssd_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [ssd_pkg::CFG_W-1:0] cfg_wdata
);
  import ssd_pkg::*;

  logic [1:0]       drive_mode;
  logic [3:0]       blink_mask;
  logic [15:0]      blink_period_ms;
  logic             common_anode;

  logic [IDX_W-1:0] scan_index, scan_index_next;
  logic             blink_phase_on, blink_phase_on_next;
  logic [15:0]      elapsed_ms, elapsed_ms_next;
  logic [3:0]       en_next;

  logic             in_fire, scan_fire;
  logic             s1_valid, s1_adv;
  logic [3:0]       s1_en;
  logic [IDX_W-1:0] s1_idx;
  logic             s1_anode;
  logic [7:0]       s1_seg;

  fill_t            fill;
  logic [ROW_W-1:0] row;

  assign s1_adv    = !out_valid || out_ready;
  assign in_ready  = !s1_valid || s1_adv;
  assign in_fire   = in_valid && in_ready;
  assign scan_fire = in_fire && (in_data.op == OP_SCAN);

  ssd_fill u_fill (
    .fire (in_fire),
    .item (in_data),
    .fill (fill)
  );

  ssd_store u_store (
    .clk     (clk),
    .rst     (rst),
    .fill    (fill),
    .rd_en   (scan_fire),
    .rd_data (row)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode      <= MODE_DARK;
      blink_mask      <= '0;
      blink_period_ms <= '0;
      common_anode    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DRIVE_MODE:   drive_mode      <= cfg_wdata[1:0];
        REG_BLINK_MASK:   blink_mask      <= cfg_wdata[3:0];
        REG_BLINK_PERIOD: blink_period_ms <= cfg_wdata;
        REG_COMMON_ANODE: common_anode    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // scan and blink timing
  always_comb begin
    scan_index_next     = scan_index;
    blink_phase_on_next = blink_phase_on;
    elapsed_ms_next     = elapsed_ms;
    en_next             = '0;
    if (in_fire) begin
      case (in_data.op)
        OP_SCAN: begin
          scan_index_next = IDX_W'(scan_index + 1'b1);
          if (drive_mode == MODE_NORMAL) begin
            en_next[scan_index] = 1'b1;
          end else if (drive_mode == MODE_BLINK) begin
            en_next[scan_index] = !blink_mask[scan_index] || blink_phase_on;
            if (elapsed_ms > blink_period_ms) begin
              blink_phase_on_next = !blink_phase_on;
              elapsed_ms_next     = '0;
            end
          end
        end
        OP_MS_TICK: begin
          if (elapsed_ms != 16'hFFFF) elapsed_ms_next = elapsed_ms + 16'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index     <= '0;
      blink_phase_on <= 1'b0;
      elapsed_ms     <= '0;
    end else begin
      scan_index     <= scan_index_next;
      blink_phase_on <= blink_phase_on_next;
      elapsed_ms     <= elapsed_ms_next;
    end
  end

  // memory read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_fire) begin
      s1_en    <= en_next;
      s1_idx   <= scan_index;
      s1_anode <= common_anode;
    end
  end

  assign s1_seg = row[s1_idx*SEG_W +: SEG_W];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_data.digit_enable  <= s1_en;
      out_data.segment_lines <= s1_anode ? ~s1_seg : s1_seg;
    end
  end

endmodule

// ===== rtl/ssd_checker.sv =====
// port-level checker for the seven-segment scan driver, bound to the top level
`include "seven_segment_scan_blink_driver_macros.svh"

module ssd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ssd_pkg::out_item_t out_data
);
  import ssd_pkg::*;

  `SSD_ASSERT_IMP(a_out_hold, clk, rst, out_valid && !out_ready, ##1 (out_valid && $stable(out_data)))
  `SSD_ASSERT_IMP(a_enable_onehot, clk, rst, out_valid, $onehot0(out_data.digit_enable))
  `SSD_ASSERT_IMP(a_stall_only_when_full, clk, rst, !in_ready, out_valid && !out_ready)
  `SSD_ASSERT_NEXT(a_reset_empty, clk, rst, !out_valid)

endmodule

bind seven_segment_scan_blink_driver ssd_checker u_ssd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
